>>> rtl/hsms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsms_pkg
// Shared types, register indexes and the quarter-wave sine table of the
// heading and speed motion sequencer.
// ----------------------------------------------------------------------------
package hsms_pkg;

	// Sine table geometry: one quarter turn holds 2^SINE_TABLE_BITS + 1 entries.
	localparam int SINE_TABLE_BITS = 8;
	localparam int SINE_TBL_N      = 1 << SINE_TABLE_BITS;
	localparam int SINE_IDX_W      = SINE_TABLE_BITS + 1;
	localparam int SINE_FRAC_SHIFT = 14 - SINE_TABLE_BITS;
	localparam int SINE_HALF       = 1 << (13 - SINE_TABLE_BITS);

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TURN_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_STEP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP      = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [15:0] RST_TURN_THRESHOLD = 16'd1820;
	localparam logic [15:0] RST_TURN_STEP      = 16'd182;
	localparam logic [15:0] RST_SPEED_STEP     = 16'd64;
	localparam logic [15:0] RST_CRUISE_SPEED   = 16'd2560;
	localparam logic [15:0] RST_TIME_STEP      = 16'd655;

	// Motion modes as seen on the motion_state output.
	typedef enum logic [2:0] {
		MODE_STOP  = 3'd0,
		MODE_TURN  = 3'd1,
		MODE_ACCEL = 3'd2,
		MODE_MOVE  = 3'd3,
		MODE_DECEL = 3'd4
	} mode_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;      // capture the input beat
		logic commit_step;  // apply a mode step that needs no multiply
		logic mul_d;        // distance = speed * time step
		logic mul_x;        // x increment from the cosine
		logic mul_y;        // y increment from the sine
		logic commit_move;  // add the increments to the position
	} hsms_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_mul;     // the pending step moves the position
	} hsms_status_t;

	// Quarter-wave table type.
	typedef logic [15:0] sine_tab_t [0:SINE_TBL_N];

	localparam longint unsigned POLY_C [0:5] = '{
		64'd1686629713, 64'd693598668, 64'd85569305,
		64'd5026996, 64'd172271, 64'd3864
	};

	// Builds the table from an odd polynomial for sin(pi/2 * x) in Q30,
	// rounded to Q15 and capped at 1.0.
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t        t;
		longint unsigned  x;
		longint unsigned  x2;
		longint unsigned  r;
		int               i;
		int               k;
		for (i = 0; i <= SINE_TBL_N; i++) begin
			x  = (longint'(i) << 30) >> SINE_TABLE_BITS;
			x2 = (x * x) >> 30;
			r  = POLY_C[5];
			for (k = 4; k >= 0; k--) begin
				r = POLY_C[k] - ((x2 * r) >> 30);
			end
			r = (x * r) >> 30;
			r = (r + 64'd16384) >> 15;
			if (r > 64'd32768) begin
				r = 64'd32768;
			end
			t[i] = r[15:0];
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

>>> rtl/hsms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsms_ctrl
// Controller state machine: takes an input beat, sequences the evaluation
// and the shared multiplier, and hands the result to the output side.
// ----------------------------------------------------------------------------
module hsms_ctrl import hsms_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  hsms_status_t status,
	output hsms_cmd_t    cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EVAL  = 6'b000010,
		ST_MUL_D = 6'b000100,
		ST_MUL_X = 6'b001000,
		ST_MUL_Y = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;
	logic   publish;

	// The state registers double as the output register, so a new result
	// may be written only once the previous beat has gone.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		publish   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (status.need_mul) begin
					state_nxt = ST_MUL_D;
				end else if (slot_free) begin
					cmd.commit_step = 1'b1;
					publish         = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			ST_MUL_D: begin
				cmd.mul_d = 1'b1;
				state_nxt = ST_MUL_X;
			end
			ST_MUL_X: begin
				cmd.mul_x = 1'b1;
				state_nxt = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				cmd.mul_y = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.commit_move = 1'b1;
					publish         = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/hsms_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsms_datapath
// Configuration registers, motion state, mode step logic and the shared
// multiplier that turns speed, time step and sine into position increments.
// ----------------------------------------------------------------------------
module hsms_datapath import hsms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [15:0]           desired_heading,
	input  hsms_cmd_t             cmd,
	output hsms_status_t          status,
	output logic [2:0]            motion_state,
	output logic [15:0]           heading,
	output logic [15:0]           speed_now,
	output logic signed [31:0]    pos_x,
	output logic signed [31:0]    pos_y
);

	// Configuration registers.
	logic [15:0] turn_threshold_q;
	logic [15:0] turn_step_q;
	logic [15:0] speed_step_q;
	logic [15:0] cruise_speed_q;
	logic [15:0] time_step_q;

	// Motion state.
	mode_t       mode_q;
	logic [15:0] heading_q;
	logic [15:0] target_q;
	logic [15:0] speed_q;
	logic [31:0] x_q;
	logic [31:0] y_q;

	// Working registers.
	logic [15:0] desired_q;
	logic [31:0] dist_q;
	logic [31:0] xinc_q;
	logic [31:0] yinc_q;

	// Step logic.
	logic [15:0] dev_d;
	logic [16:0] mag_d;
	logic        far_d;
	logic [15:0] dev_t;
	logic [16:0] mag_t;
	logic [16:0] spd_sum;
	mode_t       mode_nxt;
	logic [15:0] heading_nxt;
	logic [15:0] target_nxt;
	logic [15:0] speed_nxt;

	// Sine lookup and multiplier.
	logic [15:0]           angle;
	logic [13:0]           frac;
	logic [14:0]           frac_sum;
	logic [SINE_IDX_W-1:0] idx_raw;
	logic [SINE_IDX_W-1:0] idx;
	logic [15:0]           sine_mag;
	logic                  sine_neg;
	logic [31:0]           mul_a;
	logic [15:0]           mul_b;
	logic [47:0]           product;
	logic [47:0]           rounded;
	logic [31:0]           inc_mag;
	logic [31:0]           inc;

	// Heading errors: signed 16-bit difference, magnitude in 17 bits.
	assign dev_d = desired_q - heading_q;
	assign mag_d = dev_d[15] ? (17'h10000 - {1'b0, dev_d}) : {1'b0, dev_d};
	assign far_d = mag_d > {1'b0, turn_threshold_q};
	assign dev_t = target_q - heading_q;
	assign mag_t = dev_t[15] ? (17'h10000 - {1'b0, dev_t}) : {1'b0, dev_t};
	assign spd_sum = {1'b0, speed_q} + {1'b0, speed_step_q};

	assign status.need_mul = (mode_q == MODE_MOVE) && !far_d;

	// One step of the mode sequencer for every case without a multiply.
	always_comb begin
		mode_nxt    = mode_q;
		heading_nxt = heading_q;
		target_nxt  = target_q;
		speed_nxt   = speed_q;
		case (mode_q)
			MODE_TURN: begin
				if (mag_t <= {1'b0, turn_step_q}) begin
					heading_nxt = target_q;
					mode_nxt    = MODE_ACCEL;
				end else if (dev_t[15]) begin
					heading_nxt = heading_q - turn_step_q;
				end else begin
					heading_nxt = heading_q + turn_step_q;
				end
			end
			MODE_ACCEL: begin
				if (spd_sum >= {1'b0, cruise_speed_q}) begin
					speed_nxt = cruise_speed_q;
					mode_nxt  = MODE_MOVE;
				end else begin
					speed_nxt = spd_sum[15:0];
				end
			end
			MODE_MOVE: begin
				if (far_d) begin
					mode_nxt = MODE_DECEL;
				end
			end
			MODE_DECEL: begin
				if (speed_q <= speed_step_q) begin
					speed_nxt = 16'd0;
					mode_nxt  = MODE_STOP;
				end else begin
					speed_nxt = speed_q - speed_step_q;
				end
			end
			default: begin
				if (far_d) begin
					target_nxt = desired_q;
					mode_nxt   = MODE_TURN;
				end else begin
					heading_nxt = desired_q;
					mode_nxt    = MODE_ACCEL;
				end
			end
		endcase
	end

	// Quarter-wave lookup; the cosine is the sine a quarter turn ahead.
	always_comb begin
		angle    = cmd.mul_x ? (heading_q + 16'h4000) : heading_q;
		frac     = angle[13:0];
		frac_sum = {1'b0, frac} + 15'(SINE_HALF);
		idx_raw  = SINE_IDX_W'(frac_sum >> SINE_FRAC_SHIFT);
		idx      = angle[14] ? (SINE_IDX_W'(SINE_TBL_N) - idx_raw) : idx_raw;
		sine_mag = SINE_TAB[idx];
		sine_neg = angle[15];
	end

	// Shared multiplier: speed times time step, then distance times sine.
	always_comb begin
		mul_a   = cmd.mul_d ? {16'd0, speed_q} : dist_q;
		mul_b   = cmd.mul_d ? time_step_q : sine_mag;
		product = {16'd0, mul_a} * {32'd0, mul_b};
		rounded = (product + 48'h40_0000) >> 23;
		inc_mag = rounded[31:0];
		inc     = sine_neg ? (32'd0 - inc_mag) : inc_mag;
	end

	// Configuration and motion state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_threshold_q <= RST_TURN_THRESHOLD;
			turn_step_q      <= RST_TURN_STEP;
			speed_step_q     <= RST_SPEED_STEP;
			cruise_speed_q   <= RST_CRUISE_SPEED;
			time_step_q      <= RST_TIME_STEP;
			mode_q           <= MODE_STOP;
			heading_q        <= 16'd0;
			target_q         <= 16'd0;
			speed_q          <= 16'd0;
			x_q              <= 32'd0;
			y_q              <= 32'd0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_TURN_THRESHOLD: turn_threshold_q <= cfg_data;
					REG_TURN_STEP:      turn_step_q      <= cfg_data;
					REG_SPEED_STEP:     speed_step_q     <= cfg_data;
					REG_CRUISE_SPEED:   cruise_speed_q   <= cfg_data;
					REG_TIME_STEP:      time_step_q      <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.commit_step) begin
				mode_q    <= mode_nxt;
				heading_q <= heading_nxt;
				target_q  <= target_nxt;
				speed_q   <= speed_nxt;
			end
			if (cmd.commit_move) begin
				x_q <= x_q + xinc_q;
				y_q <= y_q + yinc_q;
			end
		end
	end

	// Working registers, no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			desired_q <= desired_heading;
		end
		if (cmd.mul_d) begin
			dist_q <= product[31:0];
		end
		if (cmd.mul_x) begin
			xinc_q <= inc;
		end
		if (cmd.mul_y) begin
			yinc_q <= inc;
		end
	end

	// The state registers are the output register.
	assign motion_state = mode_q;
	assign heading      = heading_q;
	assign speed_now    = speed_q;
	assign pos_x        = x_q;
	assign pos_y        = y_q;

endmodule

>>> rtl/heading_speed_motion_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_speed_motion_sequencer
// Five-mode motion sequencer with slew-limited heading and trapezoidal
// speed ramp; one result beat per input beat.
// ----------------------------------------------------------------------------
// Each input beat is one control tick carrying the desired heading; the
// block returns one result beat with the new mode, heading, speed and
// position. Ticks in the stopped, turning, accelerating and decelerating
// modes, and a moving tick that turns into deceleration, are evaluated and
// written without a multiply. A moving tick that advances the position also
// passes the distance, x and y multiply states, as speed times time step and
// the two sine products pass one by one through a single shared 32 by 16 bit
// multiplier. A new input beat can be accepted in the cycle after the
// previous result is written, even while it waits to be taken. The user
// must write configuration registers through cfg_write, cfg_index and
// cfg_data only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module heading_speed_motion_sequencer import hsms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [15:0]           desired_heading,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            motion_state,
	output logic [15:0]           heading,
	output logic [15:0]           speed_now,
	output logic signed [31:0]    pos_x,
	output logic signed [31:0]    pos_y
);

	hsms_cmd_t    cmd;
	hsms_status_t status;

	// Sequencing of each tick.
	hsms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// State, configuration and arithmetic.
	hsms_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.desired_heading (desired_heading),
		.cmd             (cmd),
		.status          (status),
		.motion_state    (motion_state),
		.heading         (heading),
		.speed_now       (speed_now),
		.pos_x           (pos_x),
		.pos_y           (pos_y)
	);

endmodule

>>> sim/tb_heading_speed_motion_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heading_speed_motion_sequencer
// Self-checking bench for the five-mode heading and speed sequencer: a short
// scripted walk through the mode changes and corner cases, then random ticks
// under several register settings, each result checked by script or local model.
// ----------------------------------------------------------------------------
module tb_heading_speed_motion_sequencer;
	import hsms_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int LIMIT_CYCLES = 200000;
	localparam int REPORT_MAX   = 10;
	localparam int PHASES       = 8;
	localparam int PHASE_BEATS  = 150;

	// Quarter-wave table geometry of the local model.
	localparam int QW_BITS  = SINE_TABLE_BITS;
	localparam int QW_N     = 1 << QW_BITS;
	localparam int QW_SHIFT = 14 - QW_BITS;
	localparam int QW_HALF  = 1 << (13 - QW_BITS);

	// Odd polynomial for sin(pi/2 * x), Q30 coefficients.
	localparam logic [63:0] SINE_COEF [0:5] = '{
		64'd1686629713, 64'd693598668, 64'd85569305,
		64'd5026996, 64'd172271, 64'd3864
	};

	// Register indexes that decode to nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NONE  = 3'd7;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] hdg;
		logic [15:0] spd;
		logic [31:0] px;
		logic [31:0] py;
	} motion_result_t;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	// One scripted row: a tick (index field unused) or a register write.
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [15:0]           val;
		logic                  typed;
		motion_result_t        want;
	} script_row_t;

	localparam int SCRIPT_LEN = 40;

	localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
		// From reset: a zero error goes straight to accelerating.
		'{ROW_BEAT, REG_NONE, 16'h0000, 1'b1, '{MODE_ACCEL, 16'h0000, 16'd0, 32'd0, 32'd0}},
		'{ROW_BEAT, REG_NONE, 16'hFFFF, 1'b1, '{MODE_ACCEL, 16'h0000, 16'd64, 32'd0, 32'd0}},
		// Largest speed step overshoots and clamps at cruise.
		'{ROW_CFG, REG_SPEED_STEP, 16'hFFFF, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h0000, 1'b1, '{MODE_MOVE, 16'h0000, 16'd2560, 32'd0, 32'd0}},
		'{ROW_BEAT, REG_NONE, 16'h0000, 1'b1,
			'{MODE_MOVE, 16'h0000, 16'd2560, 32'd6550, 32'd0}},
		// A half-turn error stops the vehicle, then turns it downward.
		'{ROW_BEAT, REG_NONE, 16'h8000, 1'b1,
			'{MODE_DECEL, 16'h0000, 16'd2560, 32'd6550, 32'd0}},
		'{ROW_BEAT, REG_NONE, 16'h8000, 1'b1, '{MODE_STOP, 16'h0000, 16'd0, 32'd6550, 32'd0}},
		'{ROW_BEAT, REG_NONE, 16'h8000, 1'b1, '{MODE_TURN, 16'h0000, 16'd0, 32'd6550, 32'd0}},
		'{ROW_BEAT, REG_NONE, 16'h0000, 1'b1, '{MODE_TURN, 16'hFF4A, 16'd0, 32'd6550, 32'd0}},
		'{ROW_CFG, REG_TURN_STEP, 16'h8000, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h1234, 1'b1,
			'{MODE_ACCEL, 16'h8000, 16'd0, 32'd6550, 32'd0}},
		// Zero speed step, then zero cruise and the longest time step.
		'{ROW_CFG, REG_SPEED_STEP, 16'h0000, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h8000, 1'b0, '0},
		'{ROW_CFG, REG_CRUISE_SPEED, 16'h0000, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h8000, 1'b0, '0},
		'{ROW_CFG, REG_TIME_STEP, 16'hFFFF, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h8000, 1'b0, '0},
		'{ROW_CFG, REG_SPEED_STEP, 16'h03E8, 1'b0, '0},
		'{ROW_CFG, REG_CRUISE_SPEED, 16'hFFFF, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h0000, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h0000, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h8000, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h8000, 1'b0, '0},
		// Cruise lowered below the current speed while accelerating.
		'{ROW_CFG, REG_CRUISE_SPEED, 16'h01F4, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h8000, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h8100, 1'b0, '0},
		// An error of exactly the threshold keeps moving.
		'{ROW_CFG, REG_TURN_THRESHOLD, 16'h8000, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_TURN_THRESHOLD, 16'h0000, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h8001, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h8001, 1'b0, '0},
		// Zero turn step: the turn makes no progress until the step is raised.
		'{ROW_CFG, REG_TURN_STEP, 16'h0000, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h8001, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h8001, 1'b0, '0},
		'{ROW_CFG, REG_TURN_STEP, 16'h0001, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h8001, 1'b0, '0},
		// Writes to undecoded indexes must change nothing.
		'{ROW_CFG, REG_SPARE, 16'h0000, 1'b0, '0},
		'{ROW_CFG, REG_NONE, 16'h0000, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h8001, 1'b0, '0},
		'{ROW_BEAT, REG_NONE, 16'h8001, 1'b0, '0}
	};

	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  cfg_write       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index       = REG_TURN_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data        = '0;
	logic                  in_valid        = 1'b0;
	logic                  in_ready;
	logic [15:0]           desired_heading = '0;
	logic                  out_valid;
	logic                  out_ready       = 1'b0;
	logic [2:0]            motion_state;
	logic [15:0]           heading;
	logic [15:0]           speed_now;
	logic signed [31:0]    pos_x;
	logic signed [31:0]    pos_y;

	// Model state and its copy of the registers.
	mode_t       cur_mode;
	logic [15:0] cur_hdg;
	logic [15:0] tgt_hdg;
	logic [15:0] cur_spd;
	logic [31:0] cur_x;
	logic [31:0] cur_y;
	logic [15:0] cfg_threshold;
	logic [15:0] cfg_turn_step;
	logic [15:0] cfg_speed_step;
	logic [15:0] cfg_cruise;
	logic [15:0] cfg_time_step;
	logic [15:0] qw_tab [0:QW_N];

	motion_result_t awaited_ticks [$];
	bit             no_idle      = 1'b0;
	int             fault_count  = 0;
	int             beats_sent   = 0;
	int             writes_done  = 0;
	int             results_seen = 0;
	int             cycle_count  = 0;
	int             mode_hits [0:4];

	heading_speed_motion_sequencer u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.desired_heading (desired_heading),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.motion_state    (motion_state),
		.heading         (heading),
		.speed_now       (speed_now),
		.pos_x           (pos_x),
		.pos_y           (pos_y)
	);

	always #CLK_HALF clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d ticks outstanding",
				cycle_count, awaited_ticks.size());
			$display("** heading_speed_motion_sequencer: FAILED **");
			$finish;
		end
	end

	// Quarter-wave sine table, Q15 magnitudes capped at 1.0.
	task automatic build_quarter_wave();
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] r;
		for (int i = 0; i <= QW_N; i++) begin
			x  = (64'(i) << 30) >> QW_BITS;
			x2 = (x * x) >> 30;
			r  = SINE_COEF[5];
			for (int k = 4; k >= 0; k--) begin
				r = SINE_COEF[k] - ((x2 * r) >> 30);
			end
			r = (x * r) >> 30;
			r = (r + 64'd16384) >> 15;
			if (r > 64'd32768) begin
				r = 64'd32768;
			end
			qw_tab[i] = r[15:0];
		end
	endtask

	task automatic reset_model();
		cur_mode       = MODE_STOP;
		cur_hdg        = '0;
		tgt_hdg        = '0;
		cur_spd        = '0;
		cur_x          = '0;
		cur_y          = '0;
		cfg_threshold  = RST_TURN_THRESHOLD;
		cfg_turn_step  = RST_TURN_STEP;
		cfg_speed_step = RST_SPEED_STEP;
		cfg_cruise     = RST_CRUISE_SPEED;
		cfg_time_step  = RST_TIME_STEP;
	endtask

	// Wrapped difference a - b as a signed 16-bit error; magnitude in 17 bits.
	function automatic logic [16:0] heading_error(input logic [15:0] a,
			input logic [15:0] b, output logic neg);
		logic [15:0] e;
		e = a - b;
		neg = e[15];
		if (e[15]) begin
			return 17'h10000 - {1'b0, e};
		end
		return {1'b0, e};
	endfunction

	// Signed position increment: travel times the table sine of the angle.
	function automatic logic [31:0] axis_step(input logic [31:0] travel,
			input logic [15:0] ang);
		int          idx;
		logic [63:0] prod;
		logic [31:0] m;
		idx = (int'(ang[13:0]) + QW_HALF) >> QW_SHIFT;
		if (ang[14]) begin
			idx = QW_N - idx;
		end
		prod = 64'(travel) * 64'(qw_tab[idx]) + 64'd4194304;
		m = prod[54:23];
		return ang[15] ? -m : m;
	endfunction

	// One control tick of the sequencer; returns the state after the tick.
	function automatic motion_result_t advance_motion(input logic [15:0] want_hdg);
		logic [16:0]    mag;
		logic           neg;
		logic [16:0]    sum;
		logic [31:0]    travel;
		motion_result_t r;
		case (cur_mode)
			MODE_TURN: begin
				mag = heading_error(tgt_hdg, cur_hdg, neg);
				if (mag <= {1'b0, cfg_turn_step}) begin
					cur_hdg  = tgt_hdg;
					cur_mode = MODE_ACCEL;
				end else if (neg) begin
					cur_hdg = cur_hdg - cfg_turn_step;
				end else begin
					cur_hdg = cur_hdg + cfg_turn_step;
				end
			end
			MODE_ACCEL: begin
				sum = {1'b0, cur_spd} + {1'b0, cfg_speed_step};
				if (sum >= {1'b0, cfg_cruise}) begin
					cur_spd  = cfg_cruise;
					cur_mode = MODE_MOVE;
				end else begin
					cur_spd = sum[15:0];
				end
			end
			MODE_MOVE: begin
				mag = heading_error(want_hdg, cur_hdg, neg);
				if (mag > {1'b0, cfg_threshold}) begin
					cur_mode = MODE_DECEL;
				end else begin
					travel = 32'(cur_spd) * 32'(cfg_time_step);
					cur_x  = cur_x + axis_step(travel, cur_hdg + 16'h4000);
					cur_y  = cur_y + axis_step(travel, cur_hdg);
				end
			end
			MODE_DECEL: begin
				if (cur_spd <= cfg_speed_step) begin
					cur_spd  = '0;
					cur_mode = MODE_STOP;
				end else begin
					cur_spd = cur_spd - cfg_speed_step;
				end
			end
			default: begin
				mag = heading_error(want_hdg, cur_hdg, neg);
				if (mag > {1'b0, cfg_threshold}) begin
					tgt_hdg  = want_hdg;
					cur_mode = MODE_TURN;
				end else begin
					cur_hdg  = want_hdg;
					cur_mode = MODE_ACCEL;
				end
			end
		endcase
		r.mode = cur_mode;
		r.hdg  = cur_hdg;
		r.spd  = cur_spd;
		r.px   = cur_x;
		r.py   = cur_y;
		return r;
	endfunction

	// Drop valid and hold off until every outstanding tick has returned.
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_ticks.size() != 0) begin
			@(posedge clk);
		end
		@(posedge clk);
	endtask

	// Register write; only called while the block is idle. The enable is
	// dropped between writes so that back-to-back writes stay distinct.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_TURN_THRESHOLD: cfg_threshold  = val;
			REG_TURN_STEP:      cfg_turn_step  = val;
			REG_SPEED_STEP:     cfg_speed_step = val;
			REG_CRUISE_SPEED:   cfg_cruise     = val;
			REG_TIME_STEP:      cfg_time_step  = val;
			default: ;
		endcase
		writes_done++;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one tick after a random gap; predict its result once accepted.
	task automatic send_beat(input logic [15:0] hdg, input logic typed,
			input motion_result_t typed_want);
		int             gap;
		motion_result_t r;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		desired_heading <= hdg;
		do @(posedge clk); while (!in_ready);
		r = advance_motion(hdg);
		awaited_ticks.push_back(typed ? typed_want : r);
		beats_sent++;
	endtask

	// Mostly small errors so that moves run on; some near the threshold, some wild.
	function automatic logic [15:0] pick_heading();
		int r;
		int t;
		int off;
		r = $urandom_range(0, 99);
		t = (cfg_threshold > 16'd32767) ? 32767 : int'(cfg_threshold);
		if (r < 70) begin
			off = int'($urandom_range(0, 2 * t)) - t;
			return cur_hdg + 16'(off);
		end else if (r < 82) begin
			off = t + int'($urandom_range(0, 1));
			return ($urandom_range(0, 1) != 0) ? cur_hdg + 16'(off) : cur_hdg - 16'(off);
		end
		return 16'($urandom);
	endfunction

	// Register settings for each random phase: highs, lows, reset values, then random.
	task automatic apply_profile(input int phase);
		case (phase)
			0: begin
				write_reg(REG_TURN_THRESHOLD, 16'h8000);
				write_reg(REG_TURN_STEP, 16'h8000);
				write_reg(REG_SPEED_STEP, 16'hFFFF);
				write_reg(REG_CRUISE_SPEED, 16'hFFFF);
				write_reg(REG_TIME_STEP, 16'hFFFF);
			end
			1: begin
				write_reg(REG_TURN_THRESHOLD, 16'h0000);
				write_reg(REG_TURN_STEP, 16'($urandom_range(256, 8192)));
				write_reg(REG_SPEED_STEP, 16'($urandom_range(256, 16384)));
				write_reg(REG_CRUISE_SPEED, 16'h0000);
				write_reg(REG_TIME_STEP, 16'h0000);
			end
			2: begin
				write_reg(REG_TURN_THRESHOLD, RST_TURN_THRESHOLD);
				write_reg(REG_TURN_STEP, RST_TURN_STEP);
				write_reg(REG_SPEED_STEP, RST_SPEED_STEP);
				write_reg(REG_CRUISE_SPEED, RST_CRUISE_SPEED);
				write_reg(REG_TIME_STEP, RST_TIME_STEP);
			end
			default: begin
				if ($urandom_range(0, 1) != 0) begin
					write_reg(REG_TURN_THRESHOLD, 16'($urandom_range(0, 32768)));
				end else begin
					write_reg(REG_TURN_THRESHOLD, 16'($urandom_range(500, 4000)));
				end
				write_reg(REG_TURN_STEP, 16'($urandom_range(256, 12000)));
				write_reg(REG_SPEED_STEP, 16'($urandom_range(256, 16384)));
				write_reg(REG_CRUISE_SPEED, 16'($urandom));
				write_reg(REG_TIME_STEP, 16'($urandom));
			end
		endcase
	endtask

	// Result side: random stalls, each beat checked against the oldest prediction.
	initial begin
		int             stall;
		motion_result_t want;
		motion_result_t got;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = '{motion_state, heading, speed_now, pos_x, pos_y};
			results_seen++;
			if (motion_state <= 3'd4) begin
				mode_hits[motion_state]++;
			end
			if (awaited_ticks.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_MAX) begin
					$display("result %0d arrived with no tick outstanding", results_seen);
				end
			end else begin
				want = awaited_ticks.pop_front();
				if (got !== want) begin
					fault_count++;
					if (fault_count <= REPORT_MAX) begin
						$display("result %0d: expected mode %0d hdg %h spd %h x %h y %h",
							results_seen, want.mode, want.hdg, want.spd, want.px, want.py);
						$display("result %0d:      got mode %0d hdg %h spd %h x %h y %h",
							results_seen, got.mode, got.hdg, got.spd, got.px, got.py);
					end
				end
			end
		end
	end

	// Stimulus: reset, the scripted walk, then random phases.
	initial begin
		script_row_t row;
		for (int m = 0; m <= 4; m++) begin
			mode_hits[m] = 0;
		end
		build_quarter_wave();
		reset_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			row = SCRIPT[i];
			if (row.kind == ROW_CFG) begin
				settle();
				write_reg(row.idx, row.val);
			end else begin
				send_beat(row.val, row.typed, row.want);
			end
		end

		// Odd phases run without gaps on either side.
		for (int p = 0; p < PHASES; p++) begin
			settle();
			no_idle = (p % 2) == 1;
			apply_profile(p);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				send_beat(pick_heading(), 1'b0, '0);
				if ($urandom_range(0, 63) == 0) begin
					settle();
				end
			end
		end

		settle();
		repeat (8) @(posedge clk);
		fault_count += awaited_ticks.size();
		$display("Ran %0d ticks and %0d register writes over %0d settings; %0d faults.",
			beats_sent, writes_done, PHASES + 1, fault_count);
		$display("Results by mode: stopped %0d, turning %0d, accelerating %0d, %s %0d, %s %0d",
			mode_hits[0], mode_hits[1], mode_hits[2], "moving", mode_hits[3],
			"decelerating", mode_hits[4]);
		if (fault_count == 0) begin
			$display("** heading_speed_motion_sequencer: PASSED **");
		end else begin
			$display("** heading_speed_motion_sequencer: FAILED **");
		end
		$finish;
	end

endmodule

>>> heading_speed_motion_sequencer.f
rtl/hsms_pkg.sv
rtl/hsms_ctrl.sv
rtl/hsms_datapath.sv
rtl/heading_speed_motion_sequencer.sv
sim/tb_heading_speed_motion_sequencer.sv
